@@ rtl/tsi_pkg.sv @@
// Shared types and constants of the timestamped speed interpolator.
`timescale 1ns / 1ps
package tsi_pkg;
  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned SPD_W = 32;
  localparam int unsigned WIN_W = 40;
  localparam int unsigned ENTRY_W = TIME_W + SPD_W;
  localparam int unsigned CFG_AW = 3;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd1000000000;
  localparam logic [CFG_AW-1:0] REG_WINDOW = 3'd0;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_WRITE, ST_TRIM_RD, ST_TRIM_CHK,
    ST_SCAN_RD, ST_SCAN_CHK, ST_LO_RD, ST_LO_GET, ST_DIV, ST_OUT
  } tsi_state_t;

  typedef struct packed {
    logic start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic start;
    logic [SPD_W-1:0] a;
    logic [63:0] e;
    logic [63:0] d;
  } div_req_t;
endpackage

@@ rtl/tsi_if.sv @@
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface tsi_in_if;
  import tsi_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  logic [TIME_W-1:0] time_ns;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [14:0] pix_x;
  logic [14:0] pix_y;
  logic polarity;
  modport source (output valid, kind, time_ns, vel_x, vel_y, vel_z, pix_x, pix_y, polarity,
                  input ready);
  modport sink (input valid, kind, time_ns, vel_x, vel_y, vel_z, pix_x, pix_y, polarity,
                output ready);
endinterface

interface tsi_out_if;
  import tsi_pkg::*;
  logic valid;
  logic ready;
  logic [14:0] out_x;
  logic [14:0] out_y;
  logic out_polarity;
  logic [TIME_W-1:0] out_time;
  logic [SPD_W-1:0] speed;
  modport source (output valid, out_x, out_y, out_polarity, out_time, speed, input ready);
  modport sink (input valid, out_x, out_y, out_polarity, out_time, speed, output ready);
endinterface

@@ rtl/tsi_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module tsi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

@@ rtl/tsi_sqrt.sv @@
// Bit-pair iterative integer square root of a 64-bit radicand.
`timescale 1ns / 1ps
module tsi_sqrt import tsi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  sqrt_req_t       req,
  output logic            done,
  output logic [SPD_W-1:0] root
);
  logic [63:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic busy_r, busy_nxt;
  logic [63:0] trial;

  always_comb begin
    n_nxt = n_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    trial = res_r + bit_r;
    if (req.start) begin
      n_nxt = req.radicand;
      res_nxt = '0;
      bit_nxt = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    n_r <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = busy_r && !busy_nxt && !req.start;
  assign root = res_nxt[SPD_W-1:0];
endmodule

@@ rtl/tsi_div.sv @@
// Bit-serial floor(a * e / d) with e below d; reports a nonzero remainder.
`timescale 1ns / 1ps
module tsi_div import tsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [SPD_W-1:0] quo,
  output logic             rem_nz
);
  logic [64:0] r_r, r_nxt, r1, r2;
  logic [SPD_W-1:0] q_r, q_nxt, a_r, a_nxt;
  logic [63:0] e_r, d_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic q1, q2;

  always_comb begin
    r_nxt = r_r;
    q_nxt = q_r;
    a_nxt = a_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    r1 = {r_r[63:0], 1'b0};
    q1 = 1'b0;
    if (r1 >= {1'b0, d_r}) begin
      r1 = r1 - {1'b0, d_r};
      q1 = 1'b1;
    end
    r2 = r1;
    q2 = 1'b0;
    if (a_r[SPD_W-1]) begin
      r2 = r1 + {1'b0, e_r};
      if (r2 >= {1'b0, d_r}) begin
        r2 = r2 - {1'b0, d_r};
        q2 = 1'b1;
      end
    end
    if (req.start) begin
      r_nxt = '0;
      q_nxt = '0;
      a_nxt = req.a;
      cnt_nxt = 6'(SPD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt = r2;
      q_nxt = {q_r[SPD_W-2:0], 1'b0} + SPD_W'(q1) + SPD_W'(q2);
      a_nxt = {a_r[SPD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    r_r <= r_nxt;
    q_r <= q_nxt;
    a_r <= a_nxt;
    cnt_r <= cnt_nxt;
    if (req.start) begin
      e_r <= req.e;
      d_r <= req.d;
    end
  end

  assign done = busy_r && !busy_nxt && !req.start;
  assign quo = q_nxt;
  assign rem_nz = (r_nxt != '0);
endmodule

@@ rtl/timestamped_speed_interpolator.sv @@
// Top level of the timestamped speed interpolator.
`timescale 1ns / 1ps
// The block holds up to DEPTH speed samples in a ring memory (time and Q16.16
// magnitude per entry) and handles one request at a time. A velocity sample
// keeps the block busy after it is accepted while the iterative square root
// runs and while entries older than the window are trimmed. An event scans
// the memory entries (the single-port memory is read once per entry, up to
// DEPTH entries). It then takes the newest speed or a zero-gap speed, or
// interpolates through the bit-serial divider. The result waits in an output
// register until it is taken, and the block accepts the next request only
// after that. The window register is written through the APB-style port at
// byte address 0; it must only be written while the block is idle.
module timestamped_speed_interpolator import tsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tsi_in_if.sink            in_ch,
  tsi_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);
  tsi_state_t state_r, state_nxt;
  logic [WIN_W-1:0] window_r;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [TIME_W-1:0] t_r;
  logic [14:0] px_r, py_r;
  logic pol_r;
  logic [31:0] ax_r, ay_r, az_r;
  logic [63:0] sq_sum;
  logic [TIME_W-1:0] tl_r, tl_nxt, th_r, th_nxt;
  logic [SPD_W-1:0] vl_r, vl_nxt, vh_r, vh_nxt, speed_r, speed_nxt;
  logic up_r, up_nxt;
  logic ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [TIME_W-1:0] rd_time;
  logic [SPD_W-1:0] rd_speed, mag_r;
  sqrt_req_t sqrt_req;
  div_req_t div_req;
  logic sqrt_done, div_done, div_nz;
  logic [SPD_W-1:0] sqrt_root, div_q;
  logic cfg_wr;
  logic in_acc;

  assign rd_time = ram_rdata[ENTRY_W-1:SPD_W];
  assign rd_speed = ram_rdata[SPD_W-1:0];

  tsi_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );
  tsi_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .done(sqrt_done),
                   .root(sqrt_root));
  tsi_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done),
                 .quo(div_q), .rem_nz(div_nz));

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == REG_WINDOW) ? {24'd0, window_r} : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr && cfg_paddr == REG_WINDOW) begin
      window_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.out_x = px_r;
  assign out_ch.out_y = py_r;
  assign out_ch.out_polarity = pol_r;
  assign out_ch.out_time = t_r;
  assign out_ch.speed = speed_r;

  // The ring offset of the entry a scan step looks at.
  logic [IDX_W-1:0] scan_slot;
  logic [IDX_W-1:0] wr_slot;
  logic [64:0] cutoff_sum;
  assign scan_slot = oldest_r + k_r[IDX_W-1:0];
  assign wr_slot = oldest_r + count_r[IDX_W-1:0];
  assign cutoff_sum = {2'b0, rd_time} + {25'd0, window_r};

  always_comb begin
    state_nxt = state_r;
    oldest_nxt = oldest_r;
    count_nxt = count_r;
    k_nxt = k_r;
    lo_nxt = lo_r;
    tl_nxt = tl_r;
    th_nxt = th_r;
    vl_nxt = vl_r;
    vh_nxt = vh_r;
    up_nxt = up_r;
    speed_nxt = speed_r;
    ram_we = 1'b0;
    ram_addr = scan_slot;
    ram_wdata = {t_r, mag_r};
    sqrt_req = '{start: 1'b0, radicand: sq_sum};
    div_req = '{start: 1'b0, a: (up_r ? vh_r - vl_r : vl_r - vh_r),
                e: {1'b0, t_r - tl_r}, d: {1'b0, th_r - tl_r}};
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          k_nxt = '0;
          if (in_ch.kind == KIND_SAMPLE) begin
            state_nxt = ST_SQ;
          end else if (count_r == '0) begin
            speed_nxt = '0;
            state_nxt = ST_OUT;
          end else begin
            lo_nxt = oldest_r;
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SQ: begin
        sqrt_req.start = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        if (count_r >= CNT_W'(DEPTH)) begin
          ram_addr = oldest_r;
          oldest_nxt = oldest_r + 1'b1;
        end else begin
          ram_addr = wr_slot;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = ST_TRIM_RD;
      end
      ST_TRIM_RD: begin
        ram_addr = oldest_r;
        if (count_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_TRIM_CHK;
        end
      end
      ST_TRIM_CHK: begin
        if (cutoff_sum < {2'b0, t_r}) begin
          oldest_nxt = oldest_r + 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = ST_TRIM_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (k_r == count_r) begin
          ram_addr = oldest_r + (count_r[IDX_W-1:0] - 1'b1);
          state_nxt = ST_LO_GET;
          up_nxt = 1'b0;
          lo_nxt = ram_addr;
        end else begin
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (rd_time <= t_r) begin
          lo_nxt = scan_slot;
          k_nxt = k_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end else begin
          th_nxt = rd_time;
          vh_nxt = rd_speed;
          ram_addr = lo_r;
          state_nxt = ST_LO_RD;
        end
      end
      ST_LO_RD: begin
        ram_addr = lo_r;
        up_nxt = 1'b1;
        state_nxt = ST_LO_GET;
      end
      ST_LO_GET: begin
        // Without an upper bracket the newest entry's speed is the answer.
        if (!up_r) begin
          speed_nxt = rd_speed;
          state_nxt = ST_OUT;
        end else if (th_r <= rd_time) begin
          speed_nxt = vh_r;
          state_nxt = ST_OUT;
        end else begin
          tl_nxt = rd_time;
          vl_nxt = rd_speed;
          up_nxt = (vh_r >= rd_speed);
          state_nxt = ST_DIV;
          k_nxt = '0;
        end
      end
      ST_DIV: begin
        if (k_r == '0) begin
          div_req.start = 1'b1;
          k_nxt = CNT_W'(1);
        end else if (div_done) begin
          if (up_r) begin
            speed_nxt = vl_r + div_q;
          end else begin
            speed_nxt = vl_r - div_q - SPD_W'(div_nz);
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Squares of the component magnitudes, one multiplier each. Their sum is
  // loaded straight into the square root unit when it starts.
  logic [31:0] mx, my, mz;
  assign mx = in_ch.vel_x[31] ? 32'(-in_ch.vel_x) : 32'(in_ch.vel_x);
  assign my = in_ch.vel_y[31] ? 32'(-in_ch.vel_y) : 32'(in_ch.vel_y);
  assign mz = in_ch.vel_z[31] ? 32'(-in_ch.vel_z) : 32'(in_ch.vel_z);
  assign sq_sum = 64'(ax_r * ax_r) + 64'(ay_r * ay_r) + 64'(az_r * az_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oldest_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r <= count_nxt;
    end
    k_r <= k_nxt;
    lo_r <= lo_nxt;
    tl_r <= tl_nxt;
    th_r <= th_nxt;
    vl_r <= vl_nxt;
    vh_r <= vh_nxt;
    up_r <= up_nxt;
    speed_r <= speed_nxt;
    if (in_acc) begin
      t_r <= in_ch.time_ns;
      px_r <= in_ch.pix_x;
      py_r <= in_ch.pix_y;
      pol_r <= in_ch.polarity;
      ax_r <= mx;
      ay_r <= my;
      az_r <= mz;
    end
    if (sqrt_done) begin
      mag_r <= sqrt_root;
    end
  end
endmodule

@@ rtl/tsi_checker.sv @@
// Port-level assertions for the timestamped speed interpolator.
`timescale 1ns / 1ps
module tsi_checker import tsi_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [SPD_W-1:0] speed,
  input logic cfg_pready
);
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result waits");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(speed))
    else $error("result dropped or changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("two requests in a row");
  a_rdy: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind timestamped_speed_interpolator tsi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .speed(out_ch.speed),
  .cfg_pready(cfg_pready)
);
